@@ sv/ccf_pkg.sv @@
// Shared types, constants and saturation helpers for the compression force block.
`timescale 1ns / 1ps
`default_nettype none
package ccf_pkg;

  // Working width of all sums and intermediates.
  typedef logic signed [47:0] wide_t;

  localparam wide_t WIDE_MAX = 48'sh7FFF_FFFF_FFFF;

  // pi/3 in Q32, rounded to the fraction width where it is used.
  localparam logic [63:0] PI_THIRD_Q32 = 64'd4497679235;

  // Configuration register indexes.
  localparam logic [7:0] CFG_ENERGY = 8'd0;
  localparam logic [7:0] CFG_TARGET = 8'd1;

  // Operations of the shared iterative arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    wide_t res;
  } alu_rsp_t;

  // One classified pair as it travels from the front to the back.
  typedef struct packed {
    logic [15:0]      idx;
    logic [30:0]      ri;
    logic [30:0]      rj;
    logic [2:0][32:0] d;
    logic [63:0]      dsq;
    logic             add;
    logic             last;
  } pair_t;

  // Sign-extend a working value to 64 bits.
  function automatic logic signed [63:0] wx(input wide_t v);
    return {{16{v[47]}}, v};
  endfunction

  // Clip a 64-bit value to the symmetric 48-bit working range.
  function automatic wide_t sat48(input logic signed [63:0] v);
    wide_t r;
    if (v > 64'sh7FFF_FFFF_FFFF) begin
      r = WIDE_MAX;
    end else if (v < -64'sh7FFF_FFFF_FFFF) begin
      r = -WIDE_MAX;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // Clip a working value to the symmetric 32-bit output range.
  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_7FFF_FFFF) begin
      r = -32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/ccf_ifs.sv @@
// Handshake interfaces for the pair input, force output and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none
interface ccf_pair_if;
  logic               valid;
  logic               ready;
  logic [15:0]        cell_index;
  logic signed [31:0] cell_x;
  logic signed [31:0] cell_y;
  logic signed [31:0] cell_z;
  logic [30:0]        cell_radius;
  logic signed [31:0] nbr_x;
  logic signed [31:0] nbr_y;
  logic signed [31:0] nbr_z;
  logic [30:0]        nbr_radius;
  logic               pair_valid;
  logic               last_pair;

  modport source (output valid, cell_index, cell_x, cell_y, cell_z, cell_radius,
                  nbr_x, nbr_y, nbr_z, nbr_radius, pair_valid, last_pair,
                  input ready);
  modport sink (input valid, cell_index, cell_x, cell_y, cell_z, cell_radius,
                nbr_x, nbr_y, nbr_z, nbr_radius, pair_valid, last_pair,
                output ready);
endinterface

interface ccf_force_if;
  logic               valid;
  logic               ready;
  logic [15:0]        force_cell;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;

  modport source (output valid, force_cell, force_x, force_y, force_z, input ready);
  modport sink (input valid, force_cell, force_x, force_y, force_z, output ready);
endinterface

interface ccf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/ccf_alu.sv @@
// Shared iterative unit: fixed-point multiply, fixed-point divide and integer square root.
`timescale 1ns / 1ps
`default_nettype none
module ccf_alu #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ccf_pkg::alu_req_t  req,
  input  logic [63:0]        a,
  input  ccf_pkg::wide_t     b,
  output ccf_pkg::alu_rsp_t  rsp
);

  localparam int DVW = 48 + FRACTION_BITS;
  localparam int CW  = $clog2(DVW + 1);

  logic                busy;
  logic                fin;
  ccf_pkg::alu_op_t    opr;
  logic                neg;
  logic [CW-1:0]       cnt;
  logic [95:0]         acc;
  logic [47:0]         mc;
  logic [47:0]         dvsr;
  logic [DVW-1:0]      dvd;
  logic [47:0]         rem;
  logic [47:0]         q;
  logic                over;
  logic [63:0]         sv;
  logic [35:0]         srem;
  logic [31:0]         root;

  ccf_pkg::wide_t a48;
  logic [47:0]    ua;
  logic [47:0]    ub;
  logic [48:0]    msum;
  logic [48:0]    r2;
  logic           dge;
  logic [35:0]    sr2;
  logic [35:0]    trial;
  logic           sge;
  logic [47:0]    mag;

  // Operand magnitudes at start.
  assign a48 = a[47:0];
  assign ua  = a48[47] ? 48'(-a48) : 48'(a48);
  assign ub  = b[47] ? 48'(-b) : 48'(b);

  // One step of each operation.
  assign msum  = {1'b0, acc[95:48]} + (acc[0] ? {1'b0, mc} : 49'd0);
  assign r2    = {rem, dvd[DVW-1]};
  assign dge   = r2 >= {1'b0, dvsr};
  assign sr2   = {srem[33:0], sv[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign sge   = sr2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      if (req.start) begin
        fin  <= 1'b0;
        busy <= 1'b1;
        opr  <= req.op;
        neg  <= a48[47] ^ b[47];
        acc  <= {48'd0, ub};
        mc   <= ua;
        dvsr <= ub;
        dvd  <= {ua, {FRACTION_BITS{1'b0}}};
        rem  <= '0;
        q    <= '0;
        over <= 1'b0;
        sv   <= a;
        srem <= '0;
        root <= '0;
        case (req.op)
          ccf_pkg::OP_MUL:  cnt <= CW'(48);
          ccf_pkg::OP_DIV:  cnt <= CW'(DVW);
          ccf_pkg::OP_SQRT: cnt <= CW'(32);
          default:          cnt <= CW'(48);
        endcase
      end else if (busy) begin
        case (opr)
          ccf_pkg::OP_MUL: begin
            acc <= {msum, acc[47:1]};
          end
          ccf_pkg::OP_DIV: begin
            rem  <= dge ? 48'(r2 - {1'b0, dvsr}) : r2[47:0];
            dvd  <= {dvd[DVW-2:0], 1'b0};
            over <= over | q[47];
            q    <= {q[46:0], dge};
          end
          ccf_pkg::OP_SQRT: begin
            srem <= sge ? sr2 - trial : sr2;
            root <= {root[30:0], sge};
            sv   <= {sv[61:0], 2'b00};
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt <= cnt - CW'(1);
        fin <= (cnt == CW'(1));
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        fin <= 1'b0;
      end
    end
  end

  // Final magnitude with saturation, then the sign.
  always_comb begin
    case (opr)
      ccf_pkg::OP_MUL: begin
        if (|acc[95:47+FRACTION_BITS]) begin
          mag = 48'(ccf_pkg::WIDE_MAX);
        end else begin
          mag = {1'b0, acc[46+FRACTION_BITS:FRACTION_BITS]};
        end
      end
      ccf_pkg::OP_DIV: begin
        if (dvsr == 48'd0) begin
          mag = '0;
        end else if (over || q[47]) begin
          mag = 48'(ccf_pkg::WIDE_MAX);
        end else begin
          mag = q;
        end
      end
      default: mag = {16'd0, root};
    endcase
  end

  assign rsp.done = fin;
  assign rsp.res  = (opr != ccf_pkg::OP_SQRT && neg) ? -$signed(mag) : $signed(mag);

endmodule
`default_nettype wire

@@ sv/ccf_front.sv @@
// Front end: accepts pairs, forms the offset vector and decides whether the pair overlaps.
`timescale 1ns / 1ps
`default_nettype none
module ccf_front #(
  parameter int DIMENSIONS = 3,
  parameter int INDEX_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  ccf_pair_if.sink        pairs,
  output logic            push_valid,
  input  logic            push_ready,
  output ccf_pkg::pair_t  push_data
);

  localparam logic [1:0]  AX_LAST  = 2'(DIMENSIONS - 1);
  localparam logic [15:0] IDX_MASK = (INDEX_BITS >= 16) ? 16'hFFFF
                                     : 16'((64'd1 << INDEX_BITS) - 64'd1);

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQ,
    F_CMP,
    F_PUSH
  } fstate_t;

  fstate_t         st;
  logic [1:0]      ax;
  ccf_pkg::pair_t  w;
  logic            ok;

  logic signed [31:0] cpos [3];
  logic signed [31:0] npos [3];
  logic [31:0]        big;
  logic signed [32:0] dk;
  logic [32:0]        m;
  logic [63:0]        sq;
  logic [64:0]        s;

  assign cpos[0] = pairs.cell_x;
  assign cpos[1] = pairs.cell_y;
  assign cpos[2] = pairs.cell_z;
  assign npos[0] = pairs.nbr_x;
  assign npos[1] = pairs.nbr_y;
  assign npos[2] = pairs.nbr_z;

  // Square of one axis of the offset, added to the running squared distance.
  assign big = {1'b0, w.ri} + {1'b0, w.rj};
  assign dk  = $signed(w.d[ax]);
  assign m   = dk[32] ? 33'(-dk) : 33'(dk);
  assign sq  = m[31:0] * m[31:0];
  assign s   = {1'b0, w.dsq} + {1'b0, sq};

  assign pairs.ready = (st == F_IDLE);
  assign push_valid  = (st == F_PUSH);
  assign push_data   = w;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
      ax <= '0;
    end else begin
      case (st)
        F_IDLE: begin
          if (pairs.valid) begin
            w.idx  <= pairs.cell_index & IDX_MASK;
            w.ri   <= pairs.cell_radius;
            w.rj   <= pairs.nbr_radius;
            w.dsq  <= '0;
            w.add  <= pairs.pair_valid;
            w.last <= pairs.last_pair;
            for (int k = 0; k < 3; k++) begin
              w.d[k] <= (k < DIMENSIONS)
                        ? {npos[k][31], npos[k]} - {cpos[k][31], cpos[k]} : 33'd0;
            end
            ok <= 1'b1;
            ax <= '0;
            st <= F_SQ;
          end
        end
        F_SQ: begin
          if (m >= {1'b0, big} || s[64]) begin
            ok <= 1'b0;
          end
          w.dsq <= s[63:0];
          if (ax == AX_LAST) begin
            st <= F_CMP;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        F_CMP: begin
          w.add <= w.add & ok & (w.dsq < big * big);
          st    <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            st <= F_IDLE;
          end
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/ccf_queue.sv @@
// Two-entry queue of classified pairs between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module ccf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  ccf_pkg::pair_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ccf_pkg::pair_t  pop_data
);

  ccf_pkg::pair_t slot [2];
  logic [1:0]     count;
  logic           wp;
  logic           rp;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ sv/ccf_back.sv @@
// Back end: lens volume and gradient accumulation per pair, force on the last pair.
`timescale 1ns / 1ps
`default_nettype none
module ccf_back #(
  parameter int DIMENSIONS    = 3,
  parameter int FRACTION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  output logic            head_pop,
  input  ccf_pkg::pair_t  head,
  ccf_cfg_if.sink         cfg,
  ccf_force_if.source     forces
);

  localparam logic [1:0]  AX_LAST = 2'(DIMENSIONS - 1);
  localparam logic [63:0] PI3_64  = (ccf_pkg::PI_THIRD_Q32 + (64'd1 << (31 - FRACTION_BITS)))
                                    >> (32 - FRACTION_BITS);
  localparam logic [63:0] K4_64   = ((ccf_pkg::PI_THIRD_Q32 << 2)
                                    + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
  localparam ccf_pkg::wide_t PI3  = PI3_64[47:0];
  localparam ccf_pkg::wide_t K4   = K4_64[47:0];
  localparam ccf_pkg::wide_t ONE  = 48'(64'd1 << FRACTION_BITS);

  typedef enum logic [4:0] {
    B_IDLE, B_SQRT, B_TAIL, B_POP,
    B_RI2, B_RJ2, B_D2, B_XIJ, B_DXD, B_XX, B_RX, B_DP, B_DV,
    B_GM, B_GD, B_HH, B_HC, B_CAP,
    B_V1, B_V2, B_V3, B_C1, B_C2, B_F, B_OUT
  } bstate_t;

  bstate_t             st;
  logic                issued;
  logic [1:0]          k;
  logic [30:0]         ce;
  logic [30:0]         vt;
  ccf_pkg::wide_t      ov;
  ccf_pkg::wide_t      grad [3];
  ccf_pkg::wide_t      fk [3];
  ccf_pkg::wide_t      dij;
  ccf_pkg::wide_t      ri2;
  ccf_pkg::wide_t      xij;
  ccf_pkg::wide_t      dxdd;
  ccf_pkg::wide_t      poly;
  ccf_pkg::wide_t      dv;
  ccf_pkg::wide_t      tmp;
  logic                ovalid;
  logic [15:0]         ocell;
  logic signed [31:0]  oforce [3];

  ccf_pkg::alu_req_t   req;
  ccf_pkg::alu_rsp_t   rsp;
  logic [63:0]         opa;
  ccf_pkg::wide_t      opb;
  logic                arith;
  ccf_pkg::wide_t      ri;
  ccf_pkg::wide_t      dk;
  ccf_pkg::wide_t      hgt;
  ccf_pkg::wide_t      two_h;
  logic                out_free;

  ccf_alu #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .a   (opa),
    .b   (opb),
    .rsp (rsp)
  );

  assign ri       = {17'd0, head.ri};
  assign dk       = {{15{head.d[k][32]}}, head.d[k]};
  assign hgt      = ccf_pkg::sat48(ccf_pkg::wx(ri) - ccf_pkg::wx(xij));
  assign two_h    = ccf_pkg::sat48(ccf_pkg::wx(ri) + ccf_pkg::wx(ri) - ccf_pkg::wx(xij));
  assign out_free = !ovalid || forces.ready;

  // Operation and operands of each arithmetic step.
  always_comb begin
    arith = 1'b1;
    req.op = ccf_pkg::OP_MUL;
    opa = '0;
    opb = '0;
    case (st)
      B_SQRT: begin req.op = ccf_pkg::OP_SQRT; opa = head.dsq; end
      B_RI2:  begin opa = 64'(ri); opb = ri; end
      B_RJ2:  begin opa = {33'd0, head.rj}; opb = {17'd0, head.rj}; end
      B_D2:   begin opa = 64'(dij); opb = dij; end
      B_XIJ:  begin req.op = ccf_pkg::OP_DIV; opa = ccf_pkg::wx(tmp); opb = dij <<< 1; end
      B_DXD:  begin req.op = ccf_pkg::OP_DIV; opa = ccf_pkg::wx(xij); opb = dij; end
      B_XX:   begin opa = ccf_pkg::wx(xij); opb = xij; end
      B_RX:   begin opa = 64'(ri); opb = xij; end
      B_DP:   begin opa = ccf_pkg::wx(dxdd); opb = poly; end
      B_DV:   begin opa = 64'(PI3); opb = tmp; end
      B_GM:   begin opa = ccf_pkg::wx(dv); opb = dk; end
      B_GD:   begin req.op = ccf_pkg::OP_DIV; opa = ccf_pkg::wx(tmp); opb = dij; end
      B_HH:   begin opa = ccf_pkg::wx(hgt); opb = hgt; end
      B_HC:   begin opa = ccf_pkg::wx(tmp); opb = two_h; end
      B_CAP:  begin opa = 64'(PI3); opb = tmp; end
      B_V1:   begin opa = 64'(ri); opb = ri; end
      B_V2:   begin opa = ccf_pkg::wx(tmp); opb = ri; end
      B_V3:   begin opa = 64'(K4); opb = tmp; end
      B_C1: begin
        opa = {33'd0, ce};
        opb = ccf_pkg::sat48(ccf_pkg::wx({17'd0, vt}) - ccf_pkg::wx(tmp));
      end
      B_C2:   begin req.op = ccf_pkg::OP_DIV; opa = ccf_pkg::wx(tmp); opb = {17'd0, vt}; end
      B_F:    begin opa = ccf_pkg::wx(tmp); opb = grad[k]; end
      default: arith = 1'b0;
    endcase
    req.start = arith && !issued;
  end

  assign cfg.ready     = 1'b1;
  assign head_pop      = (st == B_POP) || (st == B_OUT && out_free);
  assign forces.valid  = ovalid;
  assign forces.force_cell = ocell;
  assign forces.force_x    = oforce[0];
  assign forces.force_y    = oforce[1];
  assign forces.force_z    = oforce[2];

  // Sequencer, accumulators, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= B_IDLE;
      issued <= 1'b0;
      k      <= '0;
      ovalid <= 1'b0;
      ov     <= '0;
      ce     <= 31'd327680;
      vt     <= 31'd327680;
      for (int i = 0; i < 3; i++) begin
        grad[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          ccf_pkg::CFG_ENERGY: ce <= cfg.data[30:0];
          ccf_pkg::CFG_TARGET: vt <= cfg.data[30:0];
          default: ;
        endcase
      end
      // A word leaving in the cycle a new one is loaded is handled in B_OUT.
      if (ovalid && forces.ready && st != B_OUT) begin
        ovalid <= 1'b0;
      end
      if (req.start) begin
        issued <= 1'b1;
      end else if (rsp.done) begin
        issued <= 1'b0;
      end
      case (st)
        B_IDLE: begin
          if (head_valid) begin
            st <= head.add ? B_SQRT : B_TAIL;
          end
        end
        B_TAIL: st <= head.last ? B_V1 : B_POP;
        B_POP:  st <= B_IDLE;
        B_SQRT: if (rsp.done) begin
          dij <= rsp.res;
          st  <= (rsp.res == '0) ? B_TAIL : B_RI2;
        end
        B_RI2: if (rsp.done) begin ri2 <= rsp.res; st <= B_RJ2; end
        B_RJ2: if (rsp.done) begin tmp <= rsp.res; st <= B_D2; end
        B_D2: if (rsp.done) begin
          tmp <= ccf_pkg::sat48(ccf_pkg::wx(ri2) - ccf_pkg::wx(tmp) + ccf_pkg::wx(rsp.res));
          st  <= B_XIJ;
        end
        B_XIJ: if (rsp.done) begin xij <= rsp.res; st <= B_DXD; end
        B_DXD: if (rsp.done) begin
          dxdd <= ccf_pkg::sat48(ccf_pkg::wx(ONE) - ccf_pkg::wx(rsp.res));
          st   <= B_XX;
        end
        B_XX: if (rsp.done) begin tmp <= rsp.res; st <= B_RX; end
        B_RX: if (rsp.done) begin
          poly <= ccf_pkg::sat48(64'sd5 * ccf_pkg::wx(ri2) + 64'sd3 * ccf_pkg::wx(tmp)
                                 - 64'sd8 * ccf_pkg::wx(rsp.res));
          st   <= B_DP;
        end
        B_DP: if (rsp.done) begin tmp <= rsp.res; st <= B_DV; end
        B_DV: if (rsp.done) begin dv <= rsp.res; k <= '0; st <= B_GM; end
        B_GM: if (rsp.done) begin tmp <= rsp.res; st <= B_GD; end
        B_GD: if (rsp.done) begin
          grad[k] <= ccf_pkg::sat48(ccf_pkg::wx(grad[k]) + ccf_pkg::wx(rsp.res));
          if (k == AX_LAST) begin
            st <= B_HH;
          end else begin
            k  <= k + 2'd1;
            st <= B_GM;
          end
        end
        B_HH: if (rsp.done) begin tmp <= rsp.res; st <= B_HC; end
        B_HC: if (rsp.done) begin tmp <= rsp.res; st <= B_CAP; end
        B_CAP: if (rsp.done) begin
          ov <= ccf_pkg::sat48(ccf_pkg::wx(ov) + ccf_pkg::wx(rsp.res));
          st <= B_TAIL;
        end
        B_V1: if (rsp.done) begin tmp <= rsp.res; st <= B_V2; end
        B_V2: if (rsp.done) begin tmp <= rsp.res; st <= B_V3; end
        B_V3: if (rsp.done) begin
          tmp <= ccf_pkg::sat48(ccf_pkg::wx(rsp.res) - ccf_pkg::wx(ov));
          st  <= B_C1;
        end
        B_C1: if (rsp.done) begin tmp <= rsp.res; st <= B_C2; end
        B_C2: if (rsp.done) begin tmp <= rsp.res; k <= '0; st <= B_F; end
        B_F: if (rsp.done) begin
          fk[k] <= -rsp.res;
          if (k == AX_LAST) begin
            st <= B_OUT;
          end else begin
            k <= k + 2'd1;
          end
        end
        B_OUT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            ocell  <= head.idx;
            for (int i = 0; i < 3; i++) begin
              oforce[i] <= (i < DIMENSIONS) ? ccf_pkg::sat32(fk[i]) : 32'sd0;
              grad[i]   <= '0;
            end
            ov <= '0;
            st <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/cell_compression_force.sv @@
// Top level of the compression force block: front end, pair queue and back end.
// Each input word is one cell/neighbour pair; the last pair of a cell yields one force
// word. The front end takes a pair while idle, sums the squared offset one axis at a
// time and then compares it with the square of the radius sum. The back end does all
// arithmetic on one shared unit that retires one bit per cycle. An overlapping pair
// costs about 10 + DIMENSIONS multiplies, 2 + DIMENSIONS divides and one root; a pair
// that does not overlap skips the arithmetic, and the force on the last pair adds about
// 4 + DIMENSIONS multiplies and one divide. The two-entry queue lets the front end take
// further pairs meanwhile, and the output register holds a finished force until it is
// taken.
`timescale 1ns / 1ps
`default_nettype none
module cell_compression_force #(
  parameter int DIMENSIONS    = 3,
  parameter int FRACTION_BITS = 16,
  parameter int INDEX_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst,
  ccf_pair_if.sink     pairs,
  ccf_force_if.source  forces,
  ccf_cfg_if.sink      cfg
);

  logic            fq_valid;
  logic            fq_ready;
  ccf_pkg::pair_t  fq_data;
  logic            hd_valid;
  logic            hd_pop;
  ccf_pkg::pair_t  hd_data;

  ccf_front #(
    .DIMENSIONS (DIMENSIONS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pairs      (pairs),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data)
  );

  ccf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (hd_valid),
    .pop_ready  (hd_pop),
    .pop_data   (hd_data)
  );

  ccf_back #(
    .DIMENSIONS    (DIMENSIONS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (hd_valid),
    .head_pop   (hd_pop),
    .head       (hd_data),
    .cfg        (cfg),
    .forces     (forces)
  );

endmodule
`default_nettype wire

@@ tb/tb_cell_compression_force.sv @@
// Self-checking testbench for the cell compression force block.
`timescale 1ns / 1ps
module tb_cell_compression_force;

  localparam longint SAT_W = 64'h0000_7FFF_FFFF_FFFF;
  localparam longint SAT_O = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] PI3_Q32 = 64'd4497679235;
  localparam int FB = 16;

  typedef struct {
    logic [15:0]        idx;
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        cr;
    logic signed [31:0] nx, ny, nz;
    logic [30:0]        nr;
    logic               pv, lp;
  } pair_word_t;

  typedef struct {
    logic [15:0]        idx;
    logic signed [31:0] fx, fy, fz;
  } force_word_t;

  typedef struct {
    logic [7:0]  index;
    logic [31:0] data;
  } reg_write_t;

  logic clk = 0;
  logic rst = 1;

  ccf_pair_if  pin ();
  ccf_force_if fout ();
  ccf_cfg_if   cin ();

  cell_compression_force uut (
    .clk(clk), .rst(rst), .pairs(pin), .forces(fout), .cfg(cin)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pair_word_t  pending_pairs[$];
  force_word_t expected_forces[$];
  reg_write_t  pending_writes[$];
  pair_word_t  on_bus;
  bit          failed = 0;

  // Model copy of the registers and the running sums.
  longint energy_reg, target_reg;
  longint vol_sum;
  longint grad_sum[3];

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [63:0] absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'd0, absval(a)} * {64'd0, absval(b)};
    if (p[127:80] != 0) r = SAT_W;
    else r = p[79:16];
    if (r > SAT_W) r = SAT_W;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    logic [127:0] q;
    if (absval(b) == 0) return 0;
    q = ({64'd0, absval(a)} << FB) / {64'd0, absval(b)};
    if (q > SAT_W) q = SAT_W;
    return ((a < 0) != (b < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint round_const(logic [63:0] q32);
    return longint'((q32 + (64'd1 << (31 - FB))) >> (32 - FB));
  endfunction

  // Lens overlap volume and its gradient for one pair.
  task automatic accumulate_pair(pair_word_t w);
    longint ri, rj, dij, ri2, xij, dxdd, poly, dv, h, cap, pi3;
    longint d[3];
    logic [63:0] big, dsq, m;
    logic [64:0] s;
    ri = longint'({33'd0, w.cr});
    rj = longint'({33'd0, w.nr});
    big = ri + rj;
    pi3 = round_const(PI3_Q32);
    d[0] = longint'(w.nx) - longint'(w.cx);
    d[1] = longint'(w.ny) - longint'(w.cy);
    d[2] = longint'(w.nz) - longint'(w.cz);
    dsq = 0;
    for (int k = 0; k < 3; k++) begin
      m = absval(d[k]);
      if (m >= big) return;
      s = {1'b0, dsq} + {1'b0, m * m};
      if (s[64]) return;
      dsq = s[63:0];
    end
    if (dsq >= big * big) return;
    dij = longint'(floor_root(dsq));
    if (dij == 0) return;
    ri2 = fx_mul(ri, ri);
    xij = fx_div(clip(ri2 - fx_mul(rj, rj) + fx_mul(dij, dij), SAT_W), 2 * dij);
    dxdd = clip((longint'(1) << FB) - fx_div(xij, dij), SAT_W);
    poly = clip(5 * ri2 + 3 * fx_mul(xij, xij) - 8 * fx_mul(ri, xij), SAT_W);
    dv = fx_mul(pi3, fx_mul(dxdd, poly));
    for (int k = 0; k < 3; k++)
      grad_sum[k] = clip(grad_sum[k] + fx_div(fx_mul(dv, d[k]), dij), SAT_W);
    h = clip(ri - xij, SAT_W);
    cap = fx_mul(pi3, fx_mul(fx_mul(h, h), clip(2 * ri - xij, SAT_W)));
    vol_sum = clip(vol_sum + cap, SAT_W);
  endtask

  // Update the sums for an accepted pair and queue the force it completes.
  task automatic predict_force(pair_word_t w);
    longint r, vfree, coef, f[3];
    force_word_t e;
    if (w.pv) accumulate_pair(w);
    if (!w.lp) return;
    r = longint'({33'd0, w.cr});
    vfree = clip(fx_mul(round_const(4 * PI3_Q32), fx_mul(fx_mul(r, r), r)) - vol_sum, SAT_W);
    coef = fx_div(fx_mul(energy_reg, clip(target_reg - vfree, SAT_W)), target_reg);
    for (int k = 0; k < 3; k++) f[k] = clip(-fx_mul(coef, grad_sum[k]), SAT_O);
    e.idx = w.idx;
    e.fx = f[0][31:0];
    e.fy = f[1][31:0];
    e.fz = f[2][31:0];
    expected_forces.push_back(e);
    vol_sum = 0;
    for (int k = 0; k < 3; k++) grad_sum[k] = 0;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Pair driver: presents queued words with random gaps.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      pin.valid <= 0;
      send_gap <= 0;
    end else begin
      if (pin.valid && pin.ready) predict_force(on_bus);
      if (!pin.valid || pin.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          pin.valid <= 0;
        end else if (pending_pairs.size() > 0) begin
          on_bus = pending_pairs.pop_front();
          pin.cell_index <= on_bus.idx;
          pin.cell_x <= on_bus.cx;
          pin.cell_y <= on_bus.cy;
          pin.cell_z <= on_bus.cz;
          pin.cell_radius <= on_bus.cr;
          pin.nbr_x <= on_bus.nx;
          pin.nbr_y <= on_bus.ny;
          pin.nbr_z <= on_bus.nz;
          pin.nbr_radius <= on_bus.nr;
          pin.pair_valid <= on_bus.pv;
          pin.last_pair <= on_bus.lp;
          pin.valid <= 1;
          send_gap <= pick_gap();
        end else begin
          pin.valid <= 0;
        end
      end
    end
  end

  // Register write driver; the model copy follows each accepted write.
  always @(posedge clk) begin
    if (rst) begin
      cin.valid <= 0;
    end else begin
      if (cin.valid && cin.ready) begin
        if (cin.index == ccf_pkg::CFG_ENERGY)
          energy_reg = longint'({33'd0, cin.data[30:0]});
        else if (cin.index == ccf_pkg::CFG_TARGET)
          target_reg = longint'({33'd0, cin.data[30:0]});
      end
      if (!cin.valid || cin.ready) begin
        if (pending_writes.size() > 0) begin
          cin.index <= pending_writes[0].index;
          cin.data <= pending_writes[0].data;
          void'(pending_writes.pop_front());
          cin.valid <= 1;
        end else begin
          cin.valid <= 0;
        end
      end
    end
  end

  // Force monitor with random back-pressure and one long hold-off.
  int hold, got;
  bit pressed;
  always @(posedge clk) begin
    if (rst) begin
      fout.ready <= 0;
      hold <= 0;
      got <= 0;
      pressed <= 0;
    end else begin
      if (fout.valid && fout.ready) begin
        got <= got + 1;
        if (expected_forces.size() == 0) begin
          $error("unexpected force word for cell %0d", fout.force_cell);
          failed = 1;
        end else begin
          force_word_t e;
          e = expected_forces.pop_front();
          if (fout.force_cell !== e.idx) begin
            $error("force_cell expected %0d got %0d", e.idx, fout.force_cell);
            failed = 1;
          end
          if (fout.force_x !== e.fx) begin
            $error("force_x expected %0d got %0d", e.fx, fout.force_x);
            failed = 1;
          end
          if (fout.force_y !== e.fy) begin
            $error("force_y expected %0d got %0d", e.fy, fout.force_y);
            failed = 1;
          end
          if (fout.force_z !== e.fz) begin
            $error("force_z expected %0d got %0d", e.fz, fout.force_z);
            failed = 1;
          end
        end
      end
      if (!pressed && got == 8) begin
        pressed <= 1;
        hold <= 8000;
        fout.ready <= 0;
      end else if (hold > 0) begin
        hold <= hold - 1;
        fout.ready <= 0;
      end else if ($urandom_range(0, 99) < 70) begin
        fout.ready <= 1;
      end else begin
        hold <= pick_gap();
        fout.ready <= 0;
      end
    end
  end

  function automatic pair_word_t make_word(logic [15:0] idx, longint cx, longint cy,
                                           longint cz, longint cr, longint dx, longint dy,
                                           longint dz, longint nr, bit pv, bit lp);
    pair_word_t w;
    w.idx = idx;
    w.cx = cx[31:0];
    w.cy = cy[31:0];
    w.cz = cz[31:0];
    w.cr = cr[30:0];
    w.nx = 32'(cx + dx);
    w.ny = 32'(cy + dy);
    w.nz = 32'(cz + dz);
    w.nr = nr[30:0];
    w.pv = pv;
    w.lp = lp;
    return w;
  endfunction

  function automatic longint signed_offset(longint lim);
    longint v;
    v = $urandom_range(0, lim);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // One cell: a few pairs of mixed kinds, the last one flagged.
  task automatic queue_cell();
    logic [15:0] idx;
    longint cx, cy, cz, ri, rj, lim;
    int n, kind;
    pair_word_t w;
    idx = 16'($urandom);
    cx = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    cy = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    cz = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    ri = $urandom_range(32768, 131072);
    if ($urandom_range(0, 9) == 0) begin
      pending_pairs.push_back(make_word(idx, cx, cy, cz, ri, 0, 0, 0, 0, 0, 1));
      return;
    end
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) ri = $urandom_range(32768, 131072);
      rj = $urandom_range(16384, 131072);
      lim = (ri + rj) / 2;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        w = make_word(idx, cx, cy, cz, ri, signed_offset(lim), signed_offset(lim),
                      signed_offset(lim), rj, 1, i == n - 1);
      end else if (kind < 8) begin
        w = make_word(idx, cx, cy, cz, ri, ri + rj + $urandom_range(0, 65536),
                      signed_offset(lim), 0, rj, 1, i == n - 1);
      end else if (kind == 8) begin
        w = make_word(idx, cx, cy, cz, ri, 0, 0, 0, rj, $urandom_range(0, 1), i == n - 1);
      end else begin
        w.idx = idx;
        w.cx = $urandom; w.cy = $urandom; w.cz = $urandom;
        w.cr = 31'($urandom);
        w.nx = $urandom; w.ny = $urandom; w.nz = $urandom;
        w.nr = 31'($urandom);
        w.pv = 1'($urandom_range(0, 1));
        w.lp = (i == n - 1);
      end
      pending_pairs.push_back(w);
    end
  endtask

  task automatic write_regs(logic [31:0] e, logic [31:0] t);
    reg_write_t r;
    @(negedge clk);
    r.index = ccf_pkg::CFG_ENERGY; r.data = e;
    pending_writes.push_back(r);
    r.index = ccf_pkg::CFG_TARGET; r.data = t;
    pending_writes.push_back(r);
    do @(negedge clk); while (pending_writes.size() > 0 || cin.valid);
  endtask

  // Waits until every queued pair is in and every force is out, then lets work drain.
  task automatic drain();
    do @(negedge clk); while (pending_pairs.size() > 0 || pin.valid ||
                              expected_forces.size() > 0);
    repeat (3000) @(negedge clk);
  endtask

  task automatic queue_random(int words);
    int start;
    start = pending_pairs.size();
    @(negedge clk);
    while (pending_pairs.size() - start < words) queue_cell();
  endtask

  // Directed words: extremes and the special cases.
  task automatic queue_directed();
    longint mx;
    mx = 64'h7FFF_FFFF;
    @(negedge clk);
    // Empty cell.
    pending_pairs.push_back(make_word(16'h0000, 0, 0, 0, 65536, 0, 0, 0, 0, 0, 1));
    // Coordinates at both extremes with largest radii: too far apart.
    pending_pairs.push_back(make_word(16'hFFFF, -64'sd2147483648, -64'sd2147483648,
                                      -64'sd2147483648, mx, 64'd4294967295, 0, 0, mx, 1, 1));
    // Largest radii, nearby centres: saturating sums.
    pending_pairs.push_back(make_word(16'h5555, 64'h7FFF_0000, 64'h7FFF_0000, 64'h7FFF_0000,
                                      mx, -65536, -65536, -65536, mx, 1, 0));
    pending_pairs.push_back(make_word(16'h5555, 64'h7FFF_0000, 64'h7FFF_0000, 64'h7FFF_0000,
                                      mx, -131072, 0, 0, mx, 1, 1));
    // Coincident pair, then a normal overlap, invalid pair in the middle.
    pending_pairs.push_back(make_word(16'hAAAA, 1000, -1000, 5, 65536, 0, 0, 0, 65536, 1, 0));
    pending_pairs.push_back(make_word(16'hAAAA, 1000, -1000, 5, 65536, 40000, -30000, 20000,
                                      65536, 1, 0));
    pending_pairs.push_back(make_word(16'hAAAA, 1000, -1000, 5, 65536, 10, 10, 10, 65536, 0, 0));
    pending_pairs.push_back(make_word(16'hAAAA, 1000, -1000, 5, 65536, -50000, 60000, -10000,
                                      98304, 1, 1));
    // Exactly touching on one axis: no overlap.
    pending_pairs.push_back(make_word(16'h0001, -70000, 0, 0, 65536, 131072, 0, 0, 65536, 1, 1));
    // Zero radii on both sides, then on the cell side only.
    pending_pairs.push_back(make_word(16'h8000, 0, 0, 0, 0, 1, 0, 0, 0, 1, 1));
    pending_pairs.push_back(make_word(16'h7FFF, 0, 0, 0, 0, 0, 0, 1, 65536, 1, 1));
    // Radius change within one cell.
    pending_pairs.push_back(make_word(16'h1234, -300000, 200000, 0, 65536, 30000, 30000,
                                      -30000, 65536, 1, 0));
    pending_pairs.push_back(make_word(16'h1234, -300000, 200000, 0, 131072, -60000, 10000,
                                      40000, 32768, 1, 1));
  endtask

  initial begin
    pin.valid = 0;
    pin.cell_index = 0;
    pin.cell_x = 0; pin.cell_y = 0; pin.cell_z = 0;
    pin.cell_radius = 0;
    pin.nbr_x = 0; pin.nbr_y = 0; pin.nbr_z = 0;
    pin.nbr_radius = 0;
    pin.pair_valid = 0;
    pin.last_pair = 0;
    fout.ready = 0;
    cin.valid = 0;
    cin.index = 0;
    cin.data = 0;
    energy_reg = 327680;
    target_reg = 327680;
    vol_sum = 0;
    for (int k = 0; k < 3; k++) grad_sum[k] = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // Reset values first.
    queue_directed();
    queue_random(80);
    drain();
    write_regs(0, 1);
    queue_directed();
    queue_random(70);
    drain();
    write_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_random(80);
    drain();
    write_regs(32'h7FFF_FFFF, 1);
    queue_random(70);
    drain();
    write_regs($urandom_range(0, 1 << 20), $urandom_range(1, 1 << 20));
    queue_random(60);
    drain();
    write_regs($urandom, $urandom_range(1, 32'h7FFF_FFFF));
    queue_random(40);
    drain();

    if (!failed && expected_forces.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/ccf_pkg.sv
sv/ccf_ifs.sv
sv/ccf_alu.sv
sv/ccf_front.sv
sv/ccf_queue.sv
sv/ccf_back.sv
sv/cell_compression_force.sv
tb/tb_cell_compression_force.sv
